/* rtl/scst_pkg.sv */
// Package for the save-RAM change detector: item and result types,
// function codes, CRC-32 constants and the byte-wide CRC step.
// No dependencies; every other file of the block uses it.
package scst_pkg;

	// Function codes carried in the input tuser
	localparam logic [1:0] FUNC_CHECK = 2'd0;
	localparam logic [1:0] FUNC_BASE  = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;
	localparam logic [1:0] FUNC_NONE  = 2'd3;

	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [7:0]  BYTE_ONES    = 8'hFF;
	localparam logic [7:0]  BYTE_ZERO    = 8'h00;
	localparam logic [15:0] GAP_RESET    = 16'd5000;
	localparam logic [15:0] GAP_ZERO     = 16'd0;
	localparam logic [15:0] GAP_ONE      = 16'd1;

	// Packed output tdata width: 36 bits of fields rounded up to whole bytes
	localparam int unsigned RES_BITS   = 36;
	localparam int unsigned TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        trivial;
		logic        write_now;
		logic        throttled;
		logic        changed;
		logic [31:0] crc_value;
	} res_t;

	// Advance a reflected CRC-32 register by one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
		end
		return r;
	endfunction

endpackage

/* rtl/scst_in_stage.sv */
// Input register of the save-RAM change detector.
// Holds one accepted transaction until the core takes it; uses scst_pkg.
module scst_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  scst_pkg::in_item_t in_item,
	output logic              valid_s1,
	output scst_pkg::in_item_t item_s1,
	input  logic              take_s1
);

	// Accept whenever the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || take_s1;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Load payload on a new transaction
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* rtl/scst_core.sv */
// Core of the save-RAM change detector: running CRC, trivial-content flags,
// recorded CRC, write gap counter and the gap register. Uses scst_pkg.
module scst_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [15:0]        cfg_data,
	input  logic               valid_s1,
	input  scst_pkg::in_item_t item_s1,
	input  logic               out_free,
	output logic               take_s1,
	output logic               res_valid,
	output scst_pkg::res_t     res
);

	logic [15:0] gap_ticks_q;
	logic [31:0] crc_q;
	logic        ones_q;
	logic        zero_q;
	logic [31:0] recorded_q;
	logic [15:0] gap_left_q;

	logic        is_byte;
	logic        need_res;
	logic [31:0] crc_next;
	logic [31:0] crc_final;
	logic        ones_next;
	logic        zero_next;
	logic        trivial;
	logic        differs;
	logic        gap_open;

	// Byte step and end-of-scan decision
	always_comb begin
		is_byte   = (item_s1.func == scst_pkg::FUNC_CHECK) ||
		            (item_s1.func == scst_pkg::FUNC_BASE);
		need_res  = is_byte && item_s1.last_byte;
		crc_next  = scst_pkg::crc_byte(crc_q, item_s1.data_byte);
		crc_final = crc_next ^ scst_pkg::CRC_ALL_ONES;
		ones_next = ones_q && (item_s1.data_byte == scst_pkg::BYTE_ONES);
		zero_next = zero_q && (item_s1.data_byte == scst_pkg::BYTE_ZERO);
		trivial   = ones_next || zero_next;
		differs   = (crc_final != recorded_q);
		gap_open  = (gap_left_q == scst_pkg::GAP_ZERO);

		take_s1   = valid_s1 && (!need_res || out_free);
		res_valid = take_s1 && need_res;

		res.crc_value = crc_final;
		res.trivial   = trivial;
		res.changed   = 1'b0;
		res.throttled = 1'b0;
		res.write_now = 1'b0;
		if (item_s1.func == scst_pkg::FUNC_CHECK && differs) begin
			res.changed   = gap_open;
			res.throttled = !gap_open;
			res.write_now = gap_open && !trivial;
		end
	end

	// Hold the gap register; the user must write it only while idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_ticks_q <= scst_pkg::GAP_RESET;
		end else if (cfg_valid) begin
			gap_ticks_q <= cfg_data;
		end
	end

	// Advance scan state, recorded CRC and gap counter per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= scst_pkg::CRC_ALL_ONES;
			ones_q     <= 1'b1;
			zero_q     <= 1'b1;
			recorded_q <= '0;
			gap_left_q <= scst_pkg::GAP_ZERO;
		end else if (take_s1) begin
			unique case (item_s1.func)
				scst_pkg::FUNC_TICK: begin
					if (!gap_open) begin
						gap_left_q <= gap_left_q - scst_pkg::GAP_ONE;
					end
				end
				scst_pkg::FUNC_CHECK, scst_pkg::FUNC_BASE: begin
					if (item_s1.last_byte) begin
						crc_q  <= scst_pkg::CRC_ALL_ONES;
						ones_q <= 1'b1;
						zero_q <= 1'b1;
						if (item_s1.func == scst_pkg::FUNC_BASE) begin
							recorded_q <= crc_final;
						end else if (differs && gap_open) begin
							recorded_q <= crc_final;
							if (!trivial) begin
								gap_left_q <= gap_ticks_q;
							end
						end
					end else begin
						crc_q  <= crc_next;
						ones_q <= ones_next;
						zero_q <= zero_next;
					end
				end
				default: begin
					// unused code: drop
				end
			endcase
		end
	end

endmodule

/* rtl/scst_out_stage.sv */
// Result register of the save-RAM change detector.
// Holds one result until the receiver takes it; uses scst_pkg.
module scst_out_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                res_valid,
	input  scst_pkg::res_t                      res,
	output logic                                out_free,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [scst_pkg::TDATA_BITS-1:0]     out_data
);

	scst_pkg::res_t res_q;

	// Free when empty or draining this cycle
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= res_valid;
		end
	end

	// Load payload on a new result
	always_ff @(posedge clk) begin
		if (res_valid && out_free) begin
			res_q <= res;
		end
	end

	// Pack fields from the lowest bit up, pad with zeros
	assign out_data = {{(scst_pkg::TDATA_BITS - scst_pkg::RES_BITS){1'b0}}, res_q};

endmodule

/* rtl/sram_change_save_throttle_unit.sv */
// Top level of the save-RAM change detector with write throttling.
// Instantiates scst_in_stage, scst_core and scst_out_stage; uses scst_pkg.
//
// Usage:
//   The slave stream carries one transaction per save-RAM byte or per time
//   tick: s_tuser selects check byte, baseline byte or tick, s_tdata holds
//   the byte, s_tlast marks the final byte of a scan. A CRC-32 is kept over
//   the open scan; on the final byte one result leaves on the master stream
//   with the finished CRC and the changed, throttled, write_now and trivial
//   flags. Ticks and other bytes give no result.
//   The cfg channel writes the gap length in ticks (always ready); write it
//   only while no transaction is in flight.
// Timing:
//   An input register and a result register frame a combinational CRC
//   byte step: a final byte passes both registers before m_tvalid rises,
//   and one transaction is accepted per cycle unless a final byte waits.
//   When the receiver stalls, the result register holds; ticks and non-final
//   bytes keep flowing, and a final byte waits in the input register, which
//   then deasserts s_tready.
// Reset:
//   arst_n clears both stages, opens a new scan, zeroes the recorded CRC and
//   the gap counter, and loads the gap length with 5000.
module sram_change_save_throttle_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [15:0]                     cfg_data,   // gap_ticks
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,    // data_byte
	input  logic [1:0]                      s_tuser,    // func
	input  logic                            s_tlast,    // last_byte
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// crc_value[31:0], changed[32], throttled[33], write_now[34], trivial[35]
	output logic [scst_pkg::TDATA_BITS-1:0] m_tdata
);

	scst_pkg::in_item_t in_item;
	scst_pkg::in_item_t item_s1;
	scst_pkg::res_t     res;
	logic               valid_s1;
	logic               take_s1;
	logic               res_valid;
	logic               out_free;

	assign cfg_ready = 1'b1;

	// Gather input fields
	always_comb begin
		in_item.func      = s_tuser;
		in_item.data_byte = s_tdata;
		in_item.last_byte = s_tlast;
	end

	scst_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take_s1  (take_s1)
	);

	scst_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_free  (out_free),
		.take_s1   (take_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	scst_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

/* dv/sram_change_save_throttle_unit_test.sv */
// Testbench for sram_change_save_throttle_unit: CRC-32 save-RAM change detection,
// trivial-content filtering and tick-based write throttling over stream ports.
// Depends on scst_pkg and the RTL top level only; self-checking, no files read.
`timescale 1ns / 100ps

module sram_change_save_throttle_unit_test;
	import scst_pkg::*;

	localparam logic [31:0] REFLECTED_POLY = 32'hEDB8_8320;
	localparam int unsigned CYCLE_LIMIT    = 250000;
	localparam int unsigned REPORT_MAX     = 10;
	localparam int unsigned HOLD_CYCLES    = 300;

	typedef enum int unsigned {FILL_RANDOM, FILL_ONES, FILL_ZERO, FILL_REPEAT} fill_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [15:0]           cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic [1:0]            s_tuser;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [TDATA_BITS-1:0] m_tdata;

	// Predicted detector state
	logic [31:0] scan_crc;
	logic        scan_all_ones;
	logic        scan_all_zero;
	logic [31:0] saved_crc;
	logic [15:0] gap_count;
	logic [15:0] gap_length;

	res_t        scan_results_q[$];
	logic [7:0]  prev_scan[$];

	int unsigned items_sent;
	int unsigned burst_left;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	bit          tx_gaps;
	bit          rx_stalls;
	logic        hold_rx;
	logic [15:0] rx_pat;
	logic [3:0]  rx_phase;

	sram_change_save_throttle_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Reflected CRC-32 register advanced one data bit at a time
	function automatic logic [31:0] crc_shift_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		logic        fb;
		r = c;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r  = r >> 1;
			if (fb)
				r = r ^ REFLECTED_POLY;
		end
		return r;
	endfunction

	// Update the predicted state for one accepted transaction; queue the result if any
	task automatic predict_transaction(input logic [1:0] f, input logic [7:0] b, input logic l);
		res_t        r;
		logic [31:0] crc;
		logic        triv;
		if (f == FUNC_TICK) begin
			if (gap_count != GAP_ZERO)
				gap_count = gap_count - GAP_ONE;
		end else if (f != FUNC_NONE) begin
			scan_crc = crc_shift_byte(scan_crc, b);
			if (b != BYTE_ONES)
				scan_all_ones = 1'b0;
			if (b != BYTE_ZERO)
				scan_all_zero = 1'b0;
			if (l) begin
				crc           = ~scan_crc;
				triv          = scan_all_ones | scan_all_zero;
				scan_crc      = CRC_ALL_ONES;
				scan_all_ones = 1'b1;
				scan_all_zero = 1'b1;
				r             = '0;
				r.crc_value   = crc;
				r.trivial     = triv;
				if (f == FUNC_BASE) begin
					saved_crc = crc;
				end else if (crc != saved_crc) begin
					if (gap_count == GAP_ZERO) begin
						r.changed = 1'b1;
						saved_crc = crc;
						if (!triv) begin
							r.write_now = 1'b1;
							gap_count   = gap_length;
						end
					end else begin
						r.throttled = 1'b1;
					end
				end
				scan_results_q.push_back(r);
			end
		end
	endtask

	// Predict on every accepted input transaction
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			predict_transaction(s_tuser, s_tdata, s_tlast);
	end

	// Compare every accepted result with the oldest prediction
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[RES_BITS-1:0]);
			if (scan_results_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected result: crc %h chg %b thr %b wr %b triv %b",
						got.crc_value, got.changed, got.throttled, got.write_now,
						got.trivial);
			end else begin
				want = scan_results_q.pop_front();
				if (got.crc_value != want.crc_value || got.changed != want.changed ||
				    got.throttled != want.throttled || got.write_now != want.write_now ||
				    got.trivial != want.trivial) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("mismatch: exp %h %b %b %b %b, got %h %b %b %b %b",
							want.crc_value, want.changed, want.throttled,
							want.write_now, want.trivial, got.crc_value, got.changed,
							got.throttled, got.write_now, got.trivial);
				end
			end
		end
	end

	// Receiver: random ready pattern, or a long hold-off on request
	always @(posedge clk) begin
		if (rx_phase == 4'd0)
			rx_pat <= 16'($urandom);
		rx_phase <= rx_phase + 4'd1;
		m_tready <= !hold_rx && (!rx_stalls || rx_pat[rx_phase] || rx_pat[rx_phase ^ 4'd5]);
	end

	// Offer one transaction and hold it until accepted; insert idle gaps between bursts when tx_gaps is set
	task automatic send_item(input logic [1:0] f, input logic [7:0] b, input logic l);
		if (burst_left == 0) begin
			if (tx_gaps) begin
				s_tvalid <= 1'b0;
				s_tdata  <= 8'($urandom);
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= b;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		if (f != FUNC_NONE)
			items_sent++;
	endtask

	// Send one scan; non-final bytes occasionally take the other kind
	task automatic send_scan(input int unsigned len, input fill_t fill, input logic [1:0] kind);
		logic [7:0]  body[$];
		logic [1:0]  f;
		logic [1:0]  other;
		int unsigned i;
		other = (kind == FUNC_CHECK) ? FUNC_BASE : FUNC_CHECK;
		if (fill == FILL_REPEAT && prev_scan.size() != 0) begin
			body = prev_scan;
		end else begin
			for (i = 0; i < len; i++) begin
				case (fill)
					FILL_ONES: body.push_back(BYTE_ONES);
					FILL_ZERO: body.push_back(BYTE_ZERO);
					default:   body.push_back(8'($urandom));
				endcase
			end
		end
		for (i = 0; i < body.size(); i++) begin
			f = (i + 1 == body.size() || $urandom_range(9) != 0) ? kind : other;
			send_item(f, body[i], i + 1 == body.size());
		end
		prev_scan = body;
	endtask

	// Stop offering, wait for all predicted results, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (scan_results_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the gap length while the block is idle
	task automatic write_gap_ticks(input logic [15:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		gap_length = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_reset();
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= FUNC_CHECK;
		s_tlast   <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// Directed: baseline, unchanged, change, throttle, ticks, ignored code, trivial scans
	task automatic test_directed_cases();
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		send_item(FUNC_BASE, 8'hA5, 1'b1);
		send_item(FUNC_CHECK, 8'hA5, 1'b1);
		send_item(FUNC_CHECK, 8'h12, 1'b0);
		send_item(FUNC_BASE, 8'h34, 1'b0);
		send_item(FUNC_CHECK, 8'h56, 1'b1);
		send_item(FUNC_CHECK, 8'h01, 1'b1);
		send_item(FUNC_TICK, 8'hFF, 1'b1);
		send_item(FUNC_TICK, 8'h00, 1'b0);
		send_item(FUNC_CHECK, 8'h80, 1'b1);
		send_item(FUNC_TICK, 8'h5A, 1'b1);
		send_item(FUNC_TICK, 8'hA5, 1'b0);
		send_item(FUNC_NONE, 8'h77, 1'b1);
		send_item(FUNC_NONE, 8'h88, 1'b0);
		send_item(FUNC_CHECK, 8'hFF, 1'b0);
		send_item(FUNC_CHECK, 8'hFF, 1'b1);
		send_item(FUNC_CHECK, 8'h00, 1'b1);
		send_item(FUNC_CHECK, 8'h00, 1'b0);
		send_item(FUNC_BASE, 8'hFF, 1'b1);
		send_item(FUNC_CHECK, 8'h7F, 1'b0);
		send_item(FUNC_CHECK, 8'hFE, 1'b1);
		send_item(FUNC_BASE, 8'h00, 1'b0);
		send_item(FUNC_BASE, 8'h00, 1'b1);
		send_item(FUNC_CHECK, 8'hC3, 1'b1);
	endtask

	// Random well-formed scans mixed with tick runs and ignored codes
	task automatic test_random_scans(input int unsigned n_items);
		int unsigned stop_at;
		int unsigned pick;
		fill_t       fill;
		logic [1:0]  kind;
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
		stop_at   = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if ($urandom_range(19) == 0) begin
				tx_gaps   = 1'($urandom_range(1));
				rx_stalls = 1'($urandom_range(1));
			end
			if (pick < 6) begin
				send_item(FUNC_NONE, 8'($urandom), 1'($urandom));
			end else if (pick < 24) begin
				repeat ($urandom_range(1, 8))
					send_item(FUNC_TICK, 8'($urandom), 1'($urandom));
			end else begin
				pick = $urandom_range(99);
				fill = (pick < 10) ? FILL_ONES : (pick < 20) ? FILL_ZERO :
				       (pick < 40) ? FILL_REPEAT : FILL_RANDOM;
				kind = ($urandom_range(4) == 0) ? FUNC_BASE : FUNC_CHECK;
				send_scan($urandom_range(1, 6), fill, kind);
			end
		end
	endtask

	// Hold the receiver off for a long stretch while short scans keep coming
	task automatic test_output_backpressure();
		tx_gaps   = 1'b0;
		rx_stalls = 1'b0;
		fork
			begin
				hold_rx <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx <= 1'b0;
			end
			begin
				repeat (30)
					send_scan($urandom_range(1, 2), FILL_RANDOM,
						($urandom_range(3) == 0) ? FUNC_BASE : FUNC_CHECK);
			end
		join
	endtask

	initial begin
		scan_crc       = CRC_ALL_ONES;
		scan_all_ones  = 1'b1;
		scan_all_zero  = 1'b1;
		saved_crc      = '0;
		gap_count      = GAP_ZERO;
		gap_length     = GAP_RESET;
		items_sent     = 0;
		burst_left     = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		tx_gaps        = 1'b0;
		rx_stalls      = 1'b0;
		hold_rx        = 1'b0;
		rx_pat         = 16'hFFFF;
		rx_phase       = 4'd0;
		m_tready       = 1'b0;

		apply_reset();
		write_gap_ticks(16'd3);
		test_directed_cases();
		write_gap_ticks(GAP_ZERO);
		test_random_scans(140);
		write_gap_ticks(16'hFFFF);
		test_random_scans(120);
		write_gap_ticks(16'($urandom_range(1, 12)));
		test_output_backpressure();
		test_random_scans(140);
		settle();
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && scan_results_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/scst_pkg.sv
rtl/scst_in_stage.sv
rtl/scst_core.sv
rtl/scst_out_stage.sv
rtl/sram_change_save_throttle_unit.sv
dv/sram_change_save_throttle_unit_test.sv
